>>> hw/rtl/llcq_pkg.sv
`default_nettype none
package llcq_pkg;

	localparam int NUM_CONTEXTS_DEF = 16;
	localparam int NUM_QUEUES_DEF = 4;

	localparam int OP_W = 2;
	localparam int QSEL_W = 2;
	localparam int CTX_ID_W = 4;
	localparam int STATUS_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ENQ,
		OP_DEQ,
		OP_REMOVE,
		OP_QUERY
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK,
		ST_INVALID,
		ST_EMPTY
	} status_t;

endpackage
`default_nettype wire

>>> hw/rtl/linked_list_context_queue_top.sv
`default_nettype none
// Channel | Direction | Handshake             | Beat contents
// req     | in        | req_valid / req_ready | op, queue_sel, ctx_id
// rsp     | out       | rsp_valid / rsp_ready | status, out_ctx, is_empty
//
// Every operation has an accept cycle, which reads both link memories, and an execute
// state, which updates the queue tables, writes the links back and loads the result.
// A new request is taken only once the block is idle again, so operations never overlap;
// the link memories have registered reads, so their data is only ready in the execute state.
// If the result register still holds an untaken beat, the write-back cycle waits for it.
// Reset leaves every queue empty at once; the link memories are not cleared.
module linked_list_context_queue_top #(
	parameter int NUM_CONTEXTS = llcq_pkg::NUM_CONTEXTS_DEF,
	parameter int NUM_QUEUES = llcq_pkg::NUM_QUEUES_DEF
) (
	input wire clk,
	input wire arst_n,
	input wire req_valid,
	output logic req_ready,
	input wire [llcq_pkg::OP_W-1:0] op,
	input wire [llcq_pkg::QSEL_W-1:0] queue_sel,
	input wire [llcq_pkg::CTX_ID_W-1:0] ctx_id,
	output logic rsp_valid,
	input wire rsp_ready,
	output logic [llcq_pkg::STATUS_W-1:0] status,
	output logic [llcq_pkg::CTX_ID_W-1:0] out_ctx,
	output logic is_empty
);

	import llcq_pkg::*;

	localparam int CTX_W = $clog2(NUM_CONTEXTS);
	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int NXT_W = QW + CTX_W;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	op_t op_q;
	logic [QSEL_W-1:0] qsel_q;
	logic [CTX_ID_W-1:0] ctx_q;
	logic rsp_valid_q;
	status_t status_q;
	logic [CTX_ID_W-1:0] out_ctx_q;
	logic is_empty_q;

	logic [CTX_W-1:0] head_q [NUM_QUEUES];
	logic [CTX_W-1:0] tail_q [NUM_QUEUES];
	logic [NUM_QUEUES-1:0] busy_q;
	logic [NUM_CONTEXTS-1:0] queued_q;

	logic req_fire;
	logic [31:0] req_ctx_ext;
	logic [31:0] req_q_ext;
	logic [CTX_W-1:0] req_ci;
	logic [QW-1:0] req_qi;
	logic [CTX_W-1:0] rd_addr;

	logic [31:0] ctx_ext;
	logic [31:0] q_ext;
	logic [CTX_W-1:0] ci;
	logic [QW-1:0] qi;
	logic q_ok;
	logic c_ok;
	logic busy;
	logic [CTX_W-1:0] head;
	logic [CTX_W-1:0] tail;
	logic [CTX_W-1:0] tgt;
	logic at_head;
	logic at_tail;
	logic middle;

	logic [NXT_W-1:0] nxt_rd;
	logic [QW-1:0] tag_rd;
	logic [CTX_W-1:0] older_rd;
	logic [CTX_W-1:0] newer_rd;

	logic nxt_we;
	logic [CTX_W-1:0] nxt_waddr;
	logic [NXT_W-1:0] nxt_wdata;
	logic prv_we;
	logic [CTX_W-1:0] prv_waddr;
	logic [CTX_W-1:0] prv_wdata;

	status_t res_status;
	logic [CTX_ID_W-1:0] res_ctx;
	logic res_empty;
	logic enq;
	logic unlink;
	logic exec_fin;

	// Accept side: the dequeue reads the links of the queue's tail, the others of ctx_id.
	assign req_ready = (state_q == S_IDLE);
	assign req_fire = req_valid && req_ready;
	assign req_ctx_ext = 32'(ctx_id);
	assign req_q_ext = 32'(queue_sel);
	assign req_ci = req_ctx_ext[CTX_W-1:0];
	assign req_qi = req_q_ext[QW-1:0];
	assign rd_addr = (op_t'(op) == OP_DEQ) ? tail_q[req_qi] : req_ci;

	// The next memory also keeps the queue number of each entry for the remove check.
	llcq_ram #(
		.WIDTH(NXT_W),
		.DEPTH(NUM_CONTEXTS)
	) u_nxt_ram (
		.clk(clk),
		.wr_en(nxt_we),
		.wr_addr(nxt_waddr),
		.wr_data(nxt_wdata),
		.rd_en(req_fire),
		.rd_addr(rd_addr),
		.rd_data(nxt_rd)
	);

	llcq_ram #(
		.WIDTH(CTX_W),
		.DEPTH(NUM_CONTEXTS)
	) u_prv_ram (
		.clk(clk),
		.wr_en(prv_we),
		.wr_addr(prv_waddr),
		.wr_data(prv_wdata),
		.rd_en(req_fire),
		.rd_addr(rd_addr),
		.rd_data(newer_rd)
	);

	assign tag_rd = nxt_rd[NXT_W-1:CTX_W];
	assign older_rd = nxt_rd[CTX_W-1:0];

	assign ctx_ext = 32'(ctx_q);
	assign q_ext = 32'(qsel_q);
	assign ci = ctx_ext[CTX_W-1:0];
	assign qi = q_ext[QW-1:0];
	assign q_ok = q_ext < 32'(NUM_QUEUES);
	assign c_ok = ctx_ext < 32'(NUM_CONTEXTS);
	assign busy = q_ok && busy_q[qi];
	assign head = head_q[qi];
	assign tail = tail_q[qi];
	assign tgt = (op_q == OP_DEQ) ? tail : ci;
	assign at_head = (head == tgt);
	assign at_tail = (tail == tgt);
	assign middle = !at_head && !at_tail;

	always_comb begin
		res_status = ST_INVALID;
		res_ctx = '0;
		res_empty = 1'b1;
		enq = 1'b0;
		unlink = 1'b0;
		if (q_ok) begin
			res_empty = !busy;
			case (op_q)
				OP_ENQ: begin
					if (c_ok && !queued_q[ci]) begin
						res_status = ST_OK;
						enq = 1'b1;
						res_empty = 1'b0;
					end
				end
				OP_DEQ: begin
					if (!busy) begin
						res_status = ST_EMPTY;
					end else begin
						res_status = ST_OK;
						unlink = 1'b1;
						res_ctx = CTX_ID_W'(tail);
					end
				end
				OP_REMOVE: begin
					if (c_ok && queued_q[ci] && tag_rd == qi) begin
						res_status = ST_OK;
						unlink = 1'b1;
					end
				end
				OP_QUERY: begin
					res_status = ST_OK;
				end
				default: begin
					res_status = ST_INVALID;
				end
			endcase
			if (unlink) begin
				res_empty = at_head && at_tail;
			end
		end
	end

	assign exec_fin = (state_q == S_EXEC) && (!rsp_valid_q || rsp_ready);

	// Enqueue links the new head to the old one; a middle unlink joins both neighbors.
	assign nxt_we = exec_fin && (enq || (unlink && middle));
	assign nxt_waddr = enq ? ci : newer_rd;
	assign nxt_wdata = {qi, (enq ? (busy ? head : ci) : older_rd)};
	assign prv_we = exec_fin && ((enq && busy) || (unlink && middle));
	assign prv_waddr = enq ? head : older_rd;
	assign prv_wdata = enq ? ci : newer_rd;

	always_ff @(posedge clk) begin
		if (exec_fin && enq) begin
			head_q[qi] <= ci;
			if (!busy) begin
				tail_q[qi] <= ci;
			end
		end
		if (exec_fin && unlink) begin
			if (at_head && !at_tail) begin
				head_q[qi] <= older_rd;
			end
			if (at_tail && !at_head) begin
				tail_q[qi] <= newer_rd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			queued_q <= '0;
		end else begin
			if (exec_fin && enq) begin
				busy_q[qi] <= 1'b1;
				queued_q[ci] <= 1'b1;
			end
			if (exec_fin && unlink) begin
				queued_q[tgt] <= 1'b0;
				if (at_head && at_tail) begin
					busy_q[qi] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_QUERY;
			qsel_q <= '0;
			ctx_q <= '0;
			rsp_valid_q <= 1'b0;
			status_q <= ST_OK;
			out_ctx_q <= '0;
			is_empty_q <= 1'b1;
		end else begin
			// A finishing operation refills the result register in the cycle it drains.
			if (exec_fin) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						op_q <= op_t'(op);
						qsel_q <= queue_sel;
						ctx_q <= ctx_id;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_fin) begin
						status_q <= res_status;
						out_ctx_q <= res_ctx;
						is_empty_q <= res_empty;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status = status_q;
	assign out_ctx = out_ctx_q;
	assign is_empty = is_empty_q;

	// There are never more non-empty queues than queued contexts.
	a_busy_has_member: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(queued_q) >= $countones(busy_q))
		else $error("more busy queues than queued contexts");

	// The oldest context of a non-empty queue is still marked as queued.
	a_tail_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) && q_ok && busy_q[qi] |-> queued_q[tail])
		else $error("tail of a busy queue is not queued");

	// Link write-back never coincides with a new read of the link memories.
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(nxt_we || prv_we) |-> !req_fire)
		else $error("link write-back overlaps a new read");

	// Finishing an operation always presents its result in the next cycle.
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		exec_fin |=> rsp_valid_q && (state_q == S_IDLE))
		else $error("finished operation without a result beat");

endmodule
`default_nettype wire

>>> hw/rtl/llcq_ram.sv
`default_nettype none
module llcq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire clk,
	input wire wr_en,
	input wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input wire [WIDTH-1:0] wr_data,
	input wire rd_en,
	input wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire
